// ----- design/lru_key_value_cache_top_macros.svh -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_macros
// Assertion macros used by the cache top-level design file.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

// check a condition in the same cycle as its trigger
`define LKVC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lkvc: same-cycle check failed");

// check a condition in the cycle after its trigger
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lkvc: next-cycle check failed");

`endif

// ----- design/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int DEFAULT_ENTRIES    = 16;
    localparam int DEFAULT_KEY_BITS   = 32;
    localparam int DEFAULT_VALUE_BITS = 32;

    localparam int FIELD_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0]          CAP_RESET = 5'd16;
    localparam logic                      KIND_GET  = 1'b0;
    localparam logic                      KIND_PUT  = 1'b1;
    localparam logic signed [FIELD_W-1:0] READ_MISS = -32'sd1;
    localparam logic signed [FIELD_W-1:0] READ_PUT  = 32'sd0;

    typedef struct packed {
        logic                      kind;
        logic signed [FIELD_W-1:0] lookup_key;
        logic signed [FIELD_W-1:0] put_value;
    } in_item_t;

    typedef struct packed {
        logic                      hit;
        logic signed [FIELD_W-1:0] read_value;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic evict;
    } cmd_t;

    typedef struct packed {
        logic is_put;
    } status_t;

endpackage

// ----- design/lkvc_ram.sv -----
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lkvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer of the cache: lookup, update, post-put eviction, result handshake.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  lkvc_pkg::status_t status,
    output lkvc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_EVICT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        cmd.capture = s_valid && (state_reg == ST_IDLE);
        cmd.update  = out_free && (state_reg == ST_UPDATE);
        cmd.evict   = (state_reg == ST_EVICT);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (cmd.update) begin
                    state_next = status.is_put ? ST_EVICT : ST_IDLE;
                end
            end
            ST_EVICT: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.update) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/lkvc_datapath.sv -----
// ----------------------------------------------------------------------------
// lkvc_datapath
// Key match lanes, recency ranks, occupancy, capacity and value RAM.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
    parameter int ENTRIES    = lkvc_pkg::DEFAULT_ENTRIES,
    parameter int KEY_BITS   = lkvc_pkg::DEFAULT_KEY_BITS,
    parameter int VALUE_BITS = lkvc_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    cfg_data,
    input  lkvc_pkg::in_item_t            s_item,
    output lkvc_pkg::out_item_t           m_item,
    input  lkvc_pkg::cmd_t                cmd,
    output lkvc_pkg::status_t             status
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

    logic [KEY_BITS-1:0]          key_reg [ENTRIES];
    logic [KEY_BITS-1:0]          key_next [ENTRIES];
    logic [IDX_W-1:0]             rank_reg [ENTRIES];
    logic [IDX_W-1:0]             rank_next [ENTRIES];
    logic [ENTRIES-1:0]           valid_reg;
    logic [ENTRIES-1:0]           valid_next;
    logic [OCC_W-1:0]             occ_reg;
    logic [OCC_W-1:0]             occ_next;
    logic [lkvc_pkg::CAP_W-1:0]   capacity_reg;

    logic                         kind_reg;
    logic [KEY_BITS-1:0]          item_key_reg;
    logic [VALUE_BITS-1:0]        item_value_reg;
    logic [ENTRIES-1:0]           hit_vec_reg;
    logic                         hit_reg;
    logic [IDX_W-1:0]             hit_idx_reg;
    lkvc_pkg::out_item_t          result_reg;

    logic [KEY_BITS-1:0]          key_in;
    logic [ENTRIES-1:0]           match;
    logic [IDX_W-1:0]             hit_idx;
    logic [IDX_W-1:0]             hit_rank;
    logic [ENTRIES-1:0]           victim;
    logic [IDX_W-1:0]             victim_idx;
    logic [IDX_W-1:0]             free_idx;
    logic [ENTRIES-1:0]           ins;
    logic [CMP_W-1:0]             cap_sat;
    logic [CMP_W-1:0]             cap_ext;
    logic [CMP_W-1:0]             occ_ext;
    logic                         full;
    logic                         is_put;
    logic                         put_miss_act;
    logic                         over_cap;
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [VALUE_BITS-1:0]        ram_rdata;

    assign key_in = KEY_BITS'($unsigned(s_item.lookup_key));
    assign is_put = (kind_reg == lkvc_pkg::KIND_PUT);
    assign status.is_put = is_put;

    // compare every lane against the incoming key
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == key_in);
            hit_idx  = hit_idx | (match[i] ? IDX_W'(i) : '0);
        end
    end

    always_comb begin
        hit_rank   = '0;
        victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_rank   = hit_rank | (hit_vec_reg[i] ? rank_reg[i] : '0);
            victim[i]  = valid_reg[i] && (OCC_W'(rank_reg[i]) == occ_reg - OCC_W'(1));
            victim_idx = victim_idx | (victim[i] ? IDX_W'(i) : '0);
        end
    end

    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            ins[i] = (free_idx == IDX_W'(i));
        end
    end

    always_comb begin
        cap_ext      = CMP_W'(capacity_reg);
        cap_sat      = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
        occ_ext      = CMP_W'(occ_reg);
        full         = (occ_reg == OCC_W'(ENTRIES));
        over_cap     = (occ_ext > cap_sat);
        put_miss_act = is_put && !hit_reg && !((occ_reg == '0) && (cap_sat == '0));
    end

    always_comb begin
        key_next   = key_reg;
        rank_next  = rank_reg;
        valid_next = valid_reg;
        occ_next   = occ_reg;
        if (cmd.update) begin
            if (hit_reg) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i]) begin
                        if (hit_vec_reg[i]) begin
                            rank_next[i] = '0;
                        end else if (rank_reg[i] < hit_rank) begin
                            rank_next[i] = rank_reg[i] + IDX_W'(1);
                        end
                    end
                end
            end else if (put_miss_act) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (full ? victim[i] : ins[i]) begin
                        key_next[i]   = item_key_reg;
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end else if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                if (!full) begin
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
        end
        if (cmd.evict && over_cap) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (victim[i]) begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
            end
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    assign ram_we    = cmd.update && is_put && (hit_reg || put_miss_act);
    assign ram_waddr = hit_reg ? hit_idx_reg : (full ? victim_idx : free_idx);

    lkvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_value_reg),
        .re    (cmd.capture),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rank_reg     <= '{default: '0};
            occ_reg      <= '0;
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            occ_reg   <= occ_next;
            if (cfg_we) begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (cmd.capture) begin
            kind_reg       <= s_item.kind;
            item_key_reg   <= key_in;
            item_value_reg <= VALUE_BITS'($unsigned(s_item.put_value));
            hit_vec_reg    <= match;
            hit_reg        <= |match;
            hit_idx_reg    <= hit_idx;
        end
        if (cmd.update) begin
            result_reg.hit <= hit_reg;
            if (is_put) begin
                result_reg.read_value <= lkvc_pkg::READ_PUT;
            end else if (hit_reg) begin
                result_reg.read_value <= lkvc_pkg::FIELD_W'($unsigned(ram_rdata));
            end else begin
                result_reg.read_value <= lkvc_pkg::READ_MISS;
            end
        end
    end

    assign m_item = result_reg;

endmodule

// ----- design/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// Each accepted transfer is a get or a put and yields exactly one result
// transfer. All key lanes are compared in the acceptance cycle while the value
// RAM is read; the update state then loads the result register, once the
// result channel is free, and updates the recency ranks, keys and values. A
// put then passes through an eviction step as well, the eviction check against
// the capacity register once the put's own update has settled. The input is
// taken again as soon as the block returns to idle, even while the previous
// result still waits on the result channel. Capacity writes are accepted in
// any cycle and are seen by an item in flight from its update cycle on, so
// make them only while no transfer is in flight; values above ENTRIES act as
// ENTRIES. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_top_macros.svh"

module lru_key_value_cache_top #(
    parameter int ENTRIES    = lkvc_pkg::DEFAULT_ENTRIES,
    parameter int KEY_BITS   = lkvc_pkg::DEFAULT_KEY_BITS,
    parameter int VALUE_BITS = lkvc_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lkvc_pkg::in_item_t         s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lkvc_pkg::out_item_t        m_item
);

    lkvc_pkg::cmd_t    cmd;
    lkvc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lkvc_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .s_item   (s_item),
        .m_item   (m_item),
        .cmd      (cmd),
        .status   (status)
    );

    `LKVC_ASSERT_NEXT(a_busy_after_capture, aclk, aresetn, cmd.capture, !s_ready)
    `LKVC_ASSERT_SAME(a_update_slot_free, aclk, aresetn, cmd.update, (!m_valid || m_ready))
    `LKVC_ASSERT_NEXT(a_result_after_update, aclk, aresetn, cmd.update, m_valid)
    `LKVC_ASSERT_SAME(a_cmd_exclusive, aclk, aresetn, 1'b1, ($onehot0({cmd.capture, cmd.update, cmd.evict})))

endmodule

// ----- tb/sv/lkvc_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lkvc_tb_pkg
// Scoreboard for the LRU key-value cache. It keeps its own copy of the slots,
// their recency ages, the occupancy and the capacity, works out the reply to
// every accepted request and compares each returned reply with the oldest one
// still due.
// ----------------------------------------------------------------------------
package lkvc_tb_pkg;
    import lkvc_pkg::*;

    localparam int SLOTS = DEFAULT_ENTRIES;

    class lru_cache_mirror;
        logic [FIELD_W-1:0] slot_key[SLOTS];
        logic [FIELD_W-1:0] slot_value[SLOTS];
        bit                 slot_used[SLOTS];
        int                 slot_age[SLOTS];
        int                 fill;
        int                 capacity;
        int                 errors;
        out_item_t          due_replies[$];

        function new();
            fill     = 0;
            capacity = CAP_RESET;
            errors   = 0;
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_age[i]  = 0;
            end
        endfunction

        function int pending();
            return due_replies.size();
        endfunction

        function void refresh(int s);
            int r;
            r = slot_age[s];
            foreach (slot_used[i]) begin
                if (slot_used[i] && slot_age[i] < r) begin
                    slot_age[i]++;
                end
            end
            slot_age[s] = 0;
        endfunction

        function void drop_oldest();
            int found;
            int oldest;
            found  = -1;
            oldest = 0;
            foreach (slot_used[i]) begin
                if (slot_used[i] && (found < 0 || slot_age[i] > oldest)) begin
                    oldest = slot_age[i];
                    found  = i;
                end
            end
            if (found >= 0) begin
                slot_used[found] = 1'b0;
                slot_age[found]  = 0;
                if (fill > 0) begin
                    fill--;
                end
            end
        endfunction

        function void note_request(in_item_t req);
            int        slot;
            int        limit;
            out_item_t reply;
            limit = (capacity > SLOTS) ? SLOTS : capacity;
            slot  = -1;
            foreach (slot_used[i]) begin
                if (slot < 0 && slot_used[i] && slot_key[i] == req.lookup_key) begin
                    slot = i;
                end
            end
            reply.hit = (slot >= 0);

            if (req.kind == KIND_GET) begin
                if (slot >= 0) begin
                    refresh(slot);
                    reply.read_value = slot_value[slot];
                end else begin
                    reply.read_value = READ_MISS;
                end
                due_replies.push_back(reply);
                return;
            end

            reply.read_value = READ_PUT;
            due_replies.push_back(reply);
            if (slot >= 0) begin
                slot_value[slot] = req.put_value;
                refresh(slot);
            end else begin
                if (fill == 0 && limit == 0) begin
                    return;
                end
                if (fill >= SLOTS) begin
                    drop_oldest();
                end
                foreach (slot_used[i]) begin
                    if (slot < 0 && !slot_used[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    return;
                end
                foreach (slot_used[i]) begin
                    if (slot_used[i]) begin
                        slot_age[i]++;
                    end
                end
                slot_key[slot]   = req.lookup_key;
                slot_value[slot] = req.put_value;
                slot_used[slot]  = 1'b1;
                slot_age[slot]   = 0;
                fill++;
            end
            if (fill > limit) begin
                drop_oldest();
            end
        endfunction

        function void check_response(out_item_t got);
            out_item_t want;
            if (due_replies.size() == 0) begin
                $display("%0t: reply with none due: hit=%0b read_value=%0d",
                         $time, got.hit, got.read_value);
                errors++;
                return;
            end
            want = due_replies.pop_front();
            if (got.hit !== want.hit) begin
                $display("%0t: hit mismatch: expected %0b, actual %0b",
                         $time, want.hit, got.hit);
                errors++;
            end
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value mismatch: expected %0d, actual %0d",
                         $time, want.read_value, got.read_value);
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/lru_key_value_cache_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_test
// Drives gets and puts into the LRU key-value cache and checks every reply
// against the scoreboard. A directed opening covers extreme keys and values,
// hits, misses, updates, a zero capacity and a saturated one; random phases
// then run under a spread of capacities with small key pools so that hits,
// full-store evictions and lowered capacities all occur. Both channels idle
// at random, the reply side holds off once for a long stretch, and the
// capacity is rewritten only while the block is idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_test;
    import lkvc_pkg::*;
    import lkvc_tb_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 85;
    localparam int LONG_HOLD     = 300;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data     = '0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    in_item_t         s_item       = '0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    out_item_t        m_item;
    bit               steady       = 1'b0;
    bit               hold_request = 1'b0;

    lru_cache_mirror mirror;

    always #CLK_HALF aclk = ~aclk;

    lru_key_value_cache_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic kind, input logic [FIELD_W-1:0] key,
                             input logic [FIELD_W-1:0] value);
        in_item_t req;
        int       gap;
        req.kind       = kind;
        req.lookup_key = key;
        req.put_value  = value;
        s_valid <= 1'b1;
        s_item  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mirror.note_request(req);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        mirror.capacity = cap;
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                mirror.check_response(m_item);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (steady || $urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                m_ready <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int                 phase_caps[RANDOM_PHASES];
        logic [FIELD_W-1:0] key_pool[32];
        int                 pool_size;
        int                 put_share;
        logic               kind;
        logic [FIELD_W-1:0] key;
        mirror = new();
        phase_caps = '{16, 1, 31, 0, 17, 2, 8, 0, 0, 15};
        phase_caps[7] = $urandom_range(0, 31);
        phase_caps[8] = $urandom_range(1, 16);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store, extreme keys and values, update of a present key
        send_item(KIND_GET, 32'h8000_0000, 32'h0);
        send_item(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_item(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_item(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
        send_item(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
        send_item(KIND_GET, 32'h8000_0000, 32'h5555_5555);
        send_item(KIND_GET, 32'h7fff_ffff, 32'haaaa_aaaa);
        send_item(KIND_PUT, 32'h8000_0000, 32'h1234_5678);
        send_item(KIND_GET, 32'h8000_0000, 32'h0);
        send_item(KIND_GET, 32'h0000_0001, 32'h0);

        // zero capacity: shrink by put hits until empty, then a put into the empty store
        write_capacity(5'd0);
        repeat (4) send_item(KIND_PUT, 32'h8000_0000, $urandom);
        send_item(KIND_PUT, 32'h0000_0009, 32'h0000_0007);
        send_item(KIND_GET, 32'h0000_0009, 32'h0);

        // capacity above the slot count
        write_capacity(5'd31);
        send_item(KIND_PUT, 32'h0000_0009, 32'hdead_beef);
        send_item(KIND_GET, 32'h0000_0009, 32'h0);
        send_item(KIND_GET, 32'hffff_ffff, 32'h0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_capacity(phase_caps[p][CAP_W-1:0]);
            steady    = (p % 3 == 1);
            pool_size = $urandom_range(2, 28);
            for (int i = 0; i < pool_size; i++) begin
                key_pool[i] = $urandom;
            end
            case (p % 4)
                0: key_pool[0] = 32'h8000_0000;
                1: key_pool[0] = 32'h7fff_ffff;
                2: key_pool[0] = 32'h0000_0000;
                default: key_pool[0] = 32'hffff_ffff;
            endcase
            put_share = $urandom_range(30, 70);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == 20) begin
                    hold_request = 1'b1;
                end
                if (p == 6 && n == 40) begin
                    drain();
                end
                kind = ($urandom_range(0, 99) < put_share) ? KIND_PUT : KIND_GET;
                key  = ($urandom_range(0, 99) < 85) ?
                       key_pool[$urandom_range(0, pool_size - 1)] : $urandom;
                send_item(kind, key, $urandom);
            end
        end

        drain();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("lru_key_value_cache_top_test: done, clean");
        end else begin
            $display("lru_key_value_cache_top_test: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("lru_key_value_cache_top_test: done, errors");
        $finish;
    end

endmodule
